// ===== rtl/iwa_pkg.sv =====
package iwa_pkg;

  localparam int unsigned IWA_DEPTH = 16;
  localparam logic [31:0] IWA_INTERVAL_RESET = 32'd250000;

  typedef struct packed {
    logic [31:0]        timestamp;
    logic signed [31:0] sample;
  } iwa_in_t;

  typedef struct packed {
    logic signed [39:0] average;
    logic               updated;
  } iwa_out_t;

endpackage

// ===== rtl/interval_window_average_unit.sv =====
// Each beat on the input channel stores its sample in a ring of DEPTH entries and adds the
// time since the previous beat to a saturating elapsed total. When that total reaches the
// update interval, the filled entries are summed one per cycle through the ring's single
// read port, and the sum times 256 is divided by the entry count in a restoring divider
// that retires one quotient bit per cycle, giving a signed Q.8 average truncated toward
// zero. Every input beat yields one output beat carrying the current average and an
// updated flag. A beat that causes no update occupies the block only until its result
// enters the output register; one that does first passes through the sum and divide
// states. The divider is NW = 40 + clog2(DEPTH + 1) bits wide.
// An output beat that is stalled holds the block until the output register frees up.
module interval_window_average_unit
  import iwa_pkg::*;
#(
  parameter int unsigned DEPTH = IWA_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  iwa_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output iwa_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = 32 + CW;
  localparam int unsigned NW = SW + 8;
  localparam int unsigned SC = $clog2(NW);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e st_q, st_d;
  logic [IW-1:0] idx_q, idx_d;
  logic wrapped_q, wrapped_d;
  logic [31:0] last_ts_q, last_ts_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [31:0] interval_q, interval_d;
  logic signed [39:0] avg_q, avg_d;
  logic rd_vld_q, rd_vld_d;
  logic out_valid_q, out_valid_d;
  logic upd_q, upd_d;
  iwa_out_t out_q, out_d;

  logic [CW-1:0] iss_q, iss_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic signed [SW-1:0] acc_q, acc_d;
  logic [NW-1:0] dvd_q, dvd_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [SC-1:0] step_q, step_d;
  logic neg_q, neg_d;

  logic in_acc;
  logic idx_last;
  logic [IW-1:0] idx_next;
  logic wrap_next;
  logic [31:0] delta;
  logic [32:0] total;
  logic [31:0] elapsed_sat;
  logic do_upd;
  logic issue;
  logic signed [31:0] rd_data;
  logic [SW-1:0] acc_mag;
  logic [CW:0] trial;
  logic [CW:0] diff;
  logic ge;
  logic [NW-1:0] quot;
  logic [NW-1:0] quot_signed;

  assign in_stall_o  = (st_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign idx_last    = (idx_q == IW'(DEPTH - 1));
  assign idx_next    = idx_last ? '0 : idx_q + 1'b1;
  assign wrap_next   = wrapped_q | idx_last;
  assign delta       = in_data_i.timestamp - last_ts_q;
  assign total       = {1'b0, elapsed_q} + {1'b0, delta};
  assign elapsed_sat = total[32] ? '1 : total[31:0];
  assign do_upd      = (elapsed_sat >= interval_q);

  assign issue   = (st_q == ST_SUM) && (iss_q != cnt_q);
  assign acc_mag = acc_q[SW-1] ? SW'(-acc_q) : SW'(acc_q);

  assign trial       = {rem_q, dvd_q[NW-1]};
  assign diff        = trial - {1'b0, cnt_q};
  assign ge          = (trial >= {1'b0, cnt_q});
  assign quot        = {dvd_q[NW-2:0], ge};
  assign quot_signed = neg_q ? (~quot + 1'b1) : quot;

  iwa_ring #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc),
    .wr_addr_i (idx_q),
    .wr_data_i (in_data_i.sample),
    .rd_addr_i (iss_q[IW-1:0]),
    .rd_data_o (rd_data)
  );

  always_comb begin
    st_d        = st_q;
    idx_d       = idx_q;
    wrapped_d   = wrapped_q;
    last_ts_d   = last_ts_q;
    elapsed_d   = elapsed_q;
    interval_d  = cfg_we_i ? cfg_wdata_i : interval_q;
    avg_d       = avg_q;
    rd_vld_d    = issue;
    out_valid_d = out_valid_q && out_stall_i;
    upd_d       = upd_q;
    out_d       = out_q;
    iss_d       = issue ? iss_q + 1'b1 : iss_q;
    cnt_d       = cnt_q;
    acc_d       = rd_vld_q ? acc_q + SW'(rd_data) : acc_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    step_d      = step_q;
    neg_d       = neg_q;

    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          last_ts_d = in_data_i.timestamp;
          if (do_upd) begin
            idx_d     = '0;
            wrapped_d = 1'b0;
            elapsed_d = '0;
            cnt_d     = wrap_next ? CW'(DEPTH) : CW'(idx_next);
            iss_d     = '0;
            acc_d     = '0;
            upd_d     = 1'b1;
            st_d      = ST_SUM;
          end else begin
            idx_d     = idx_next;
            wrapped_d = wrap_next;
            elapsed_d = elapsed_sat;
            upd_d     = 1'b0;
            st_d      = ST_DONE;
          end
        end
      end
      ST_SUM: begin
        if (!issue && !rd_vld_q) begin
          dvd_d  = {acc_mag, 8'b0};
          neg_d  = acc_q[SW-1];
          rem_d  = '0;
          step_d = SC'(NW - 1);
          st_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        dvd_d  = quot;
        rem_d  = ge ? diff[CW-1:0] : trial[CW-1:0];
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          avg_d = quot_signed[39:0];
          st_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_d.average = avg_q;
          out_d.updated = upd_q;
          st_d          = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      idx_q       <= '0;
      wrapped_q   <= 1'b0;
      last_ts_q   <= '0;
      elapsed_q   <= '0;
      interval_q  <= IWA_INTERVAL_RESET;
      avg_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      upd_q       <= 1'b0;
    end else begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      wrapped_q   <= wrapped_d;
      last_ts_q   <= last_ts_d;
      elapsed_q   <= elapsed_d;
      interval_q  <= interval_d;
      avg_q       <= avg_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      upd_q       <= upd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    iss_q  <= iss_d;
    cnt_q  <= cnt_d;
    acc_q  <= acc_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    neg_q  <= neg_d;
  end

endmodule

// ===== rtl/iwa_ring.sv =====
module iwa_ring
  import iwa_pkg::*;
#(
  parameter int unsigned DEPTH = IWA_DEPTH,
  parameter int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [IW-1:0]        wr_addr_i,
  input  logic signed [31:0]   wr_data_i,
  input  logic [IW-1:0]        rd_addr_i,
  output logic signed [31:0]   rd_data_o
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/iwa_checker.sv =====
module iwa_checker
  import iwa_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input iwa_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled output beat changed or vanished.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input accepted again in the cycle after a beat.");

  a_result_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("Block went idle without presenting a result beat.");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Result beat appeared while the block was idle.");

endmodule

bind interval_window_average_unit iwa_checker u_iwa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import iwa_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  iwa_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  iwa_out_t    out_data;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  interval_window_average_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Local copy of the block state used to predict each result beat.
  logic signed [31:0] window_ring [IWA_DEPTH];
  int unsigned        fill_index = 0;
  bit                 ring_wrapped = 1'b0;
  logic [31:0]        prev_stamp = '0;
  logic [31:0]        elapsed_total = '0;
  logic [31:0]        update_interval = IWA_INTERVAL_RESET;
  logic signed [39:0] held_average = '0;

  iwa_out_t    avg_expect_q [$];
  logic [31:0] now_stamp = '0;
  int unsigned mismatch_count = 0;
  int unsigned hold_len = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic window_step(input logic [31:0] stamp, input logic signed [31:0] smp);
    logic [31:0] delta;
    logic [32:0] total;
    longint      sum;
    int unsigned count;
    iwa_out_t    beat;
    window_ring[fill_index] = smp;
    fill_index = (fill_index + 1) % IWA_DEPTH;
    if (fill_index == 0) begin
      ring_wrapped = 1'b1;
    end
    delta = stamp - prev_stamp;
    prev_stamp = stamp;
    total = {1'b0, elapsed_total} + {1'b0, delta};
    elapsed_total = total[32] ? 32'hFFFF_FFFF : total[31:0];
    beat.updated = 1'b0;
    if (elapsed_total >= update_interval) begin
      count = ring_wrapped ? IWA_DEPTH : fill_index;
      sum = 0;
      for (int i = 0; i < count; i++) begin
        sum += window_ring[i];
      end
      held_average = (sum * 256) / longint'(count);
      fill_index = 0;
      ring_wrapped = 1'b0;
      elapsed_total = '0;
      beat.updated = 1'b1;
    end
    beat.average = held_average;
    avg_expect_q.push_back(beat);
  endtask

  task automatic send_beat(input logic [31:0] delta, input logic [31:0] smp);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    now_stamp = now_stamp + delta;
    in_valid <= 1'b1;
    in_data <= '{timestamp: now_stamp, sample: smp};
    do @(posedge clk); while (in_stall);
    window_step(now_stamp, smp);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (avg_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_interval(input logic [31:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    update_interval = value;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_delta(input logic [31:0] ival);
    longint span;
    if ($urandom_range(0, 15) == 0) begin
      return $urandom;
    end
    span = (longint'(ival) * 2) / $urandom_range(1, 20);
    if (span > 64'h0_FFFF_FFFF) begin
      span = 64'h0_FFFF_FFFF;
    end
    return $urandom_range(0, 32'(span));
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_default_interval();
    send_beat(32'd100000, 32'h7FFF_FFFF);
    send_beat(32'd150000, 32'h8000_0000);
  endtask

  task automatic test_zero_interval();
    write_interval(32'd0);
    send_beat(32'hFFFF_FFFF - now_stamp, 32'h7FFF_FFFF);
    send_beat(32'd1, 32'h8000_0000);
    send_beat(32'd0, 32'hFFFF_FFFF);
    send_beat(32'd0, 32'h0000_0000);
  endtask

  task automatic test_ring_wrap();
    write_interval(32'd17);
    for (int i = 0; i < 17; i++) begin
      send_beat(32'd1, (i % 3 == 0) ? 32'h7FFF_FFFF : 32'h8000_0001);
    end
  endtask

  task automatic test_elapsed_saturation();
    write_interval(32'hFFFF_FFFF);
    send_beat(32'hF000_0000, 32'h8000_0000);
    send_beat(32'hF000_0000, 32'h0000_0003);
  endtask

  // The receiver holds off long enough that the block fills and stalls its input.
  task automatic test_output_backpressure();
    write_interval($urandom_range(1, 20));
    hold_len = 400;
    repeat (40) send_beat($urandom_range(0, 8), pick_sample());
    drain_results();
  endtask

  task automatic test_random_phases(input int unsigned target);
    int unsigned sent;
    int unsigned n;
    logic [31:0] ival;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0: ival = 32'd0;
        1: ival = 32'hFFFF_FFFF;
        2: ival = 32'd1;
        3, 4: ival = $urandom;
        default: ival = $urandom_range(2, 5000);
      endcase
      write_interval(ival);
      n = $urandom_range(40, 120);
      repeat (n) send_beat(pick_delta(ival), pick_sample());
      sent += n;
    end
  endtask

  task automatic test_back_to_back();
    drain_results();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    test_random_phases(200);
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_stall <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    iwa_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (avg_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("[%0t] unexpected result beat: average %0d updated %0b",
                   $realtime, out_data.average, out_data.updated);
        end
      end else begin
        want = avg_expect_q.pop_front();
        if (out_data.average !== want.average || out_data.updated !== want.updated) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] result mismatch: expected average %0d updated %0b,",
                     $realtime, want.average, want.updated);
            $display("    got average %0d updated %0b", out_data.average, out_data.updated);
          end
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_interval();
    test_zero_interval();
    test_ring_wrap();
    test_elapsed_saturation();
    test_output_backpressure();
    test_random_phases(1300);
    test_back_to_back();
    drain_results();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && avg_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/iwa_pkg.sv
rtl/iwa_ring.sv
rtl/interval_window_average_unit.sv
rtl/iwa_checker.sv
verif/tb_top.sv
